// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the stair ramp planner.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);
// ante implies cons in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/ssrp_pkg.sv =====
// Package of the stair ramp planner: field widths, payload and command types,
// codes and state enum. No dependencies.
package ssrp_pkg;

    localparam int MAX_STAIRS_DEF = 16;

    localparam int IDX_W    = 4;
    localparam int STEPS_W  = 8;
    localparam int FREQ_W   = 16;
    localparam int PULSE_W  = 16;
    localparam int SC_W     = 5;
    localparam int PPS_W    = 7;
    localparam int SEG_W    = STEPS_W + PPS_W;
    // 2 * 127 * 16 * 255 fits in 20 bits
    localparam int ACC_W    = 20;
    localparam int INDEX_SPAN = 2 ** IDX_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_STAIR_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_STEP = 1'b1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_MOVE = 1'b1;

    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RISE,
        ST_CRUISE,
        ST_FALL
    } t_state;

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   stair_index;
        logic [STEPS_W-1:0] stair_steps;
        logic [FREQ_W-1:0]  stair_freq;
        logic [PULSE_W-1:0] pulse_total;
        logic               direction;
    } t_in_item;

    typedef struct packed {
        logic [PULSE_W-1:0] seg_pulses;
        logic [FREQ_W-1:0]  seg_freq;
        logic               seg_direction;
        t_phase             seg_phase;
        logic               last;
    } t_out_item;

    // command held in the queue between front and back
    typedef struct packed {
        logic               is_move;
        logic [IDX_W-1:0]   stair_index;
        logic [STEPS_W-1:0] stair_steps;
        logic [FREQ_W-1:0]  stair_freq;
        logic [PULSE_W-1:0] pulse_total;
        logic               direction;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [SC_W-1:0]  stair_count;
        logic [PPS_W-1:0] pulses_per_step;
    } t_cfg;

endpackage

// ===== rtl/ssrp_stream_if.sv =====
// Valid/ready stream interface used by the planner's channels.
// Payload type is a parameter; no other dependencies.
interface ssrp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/ssrp_front.sv =====
// Front end: accepts input items, drops items that do nothing, queues commands.
// Depends on ssrp_pkg and ssrp_stream_if.
module ssrp_front
    import ssrp_pkg::*;
#(
    parameter int MAX_STAIRS = MAX_STAIRS_DEF
) (
    ssrp_stream_if.sink i_in,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic keep;

    assign i_in.ready = !i_q_stat.full;

    always_comb begin
        if (i_in.data.mode == MODE_MOVE) begin
            keep = (i_in.data.pulse_total != '0);
        end else begin
            keep = (32'(i_in.data.stair_index) < 32'(MAX_STAIRS));
        end
    end

    assign o_push = i_in.valid && i_in.ready && keep;

    assign o_cmd.is_move     = (i_in.data.mode == MODE_MOVE);
    assign o_cmd.stair_index = i_in.data.stair_index;
    assign o_cmd.stair_steps = i_in.data.stair_steps;
    assign o_cmd.stair_freq  = i_in.data.stair_freq;
    assign o_cmd.pulse_total = i_in.data.pulse_total;
    assign o_cmd.direction   = i_in.data.direction;

endmodule

// ===== rtl/ssrp_queue.sv =====
// Short command FIFO between front and back of the planner.
// Depends on ssrp_pkg.
module ssrp_queue
    import ssrp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (32'(r_wr_ptr) == Q_DEPTH - 1) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (32'(r_rd_ptr) == Q_DEPTH - 1) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

// ===== rtl/ssrp_back.sv =====
// Back end: holds the stair table, scans it for the turn stair and emits the
// segments of each move through an output register. Depends on ssrp_pkg, ssrp_stream_if.
module ssrp_back
    import ssrp_pkg::*;
#(
    parameter int MAX_STAIRS = MAX_STAIRS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_pop,
    ssrp_stream_if.source o_out
);

    localparam int TBL_AW = (MAX_STAIRS > 1) ? $clog2(MAX_STAIRS) : 1;
    localparam int LIM    = (MAX_STAIRS < INDEX_SPAN) ? MAX_STAIRS : INDEX_SPAN;
    localparam int CNT_W  = $clog2(LIM + 1);

    // stair table, no reset
    logic [STEPS_W-1:0] r_steps [MAX_STAIRS];
    logic [FREQ_W-1:0]  r_freq  [MAX_STAIRS];

    t_state              r_state, n_state;
    logic [TBL_AW-1:0]   r_idx, n_idx;
    logic [TBL_AW-1:0]   r_cidx, n_cidx;
    logic [CNT_W-1:0]    r_rise, n_rise;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [PULSE_W-1:0]  r_cruise, n_cruise;
    logic [PULSE_W-1:0]  r_npulses, n_npulses;
    logic                r_dir, n_dir;
    logic                r_out_valid;
    t_out_item           r_out_data;

    logic [CNT_W-1:0]    s_eff;
    logic [PPS_W-1:0]    p_eff;
    logic [TBL_AW-1:0]   rd_addr;
    logic [STEPS_W-1:0]  rd_steps;
    logic [FREQ_W-1:0]   rd_freq;
    logic [SEG_W-1:0]    seg;
    logic [ACC_W-1:0]    acc_next;
    logic                out_free;
    logic                tbl_we;
    logic                emit;
    t_out_item           emit_data;

    always_comb begin
        if (i_cfg.stair_count == '0) begin
            s_eff = CNT_W'(1);
        end else if (i_cfg.stair_count > SC_W'(LIM)) begin
            s_eff = CNT_W'(LIM);
        end else begin
            s_eff = CNT_W'(i_cfg.stair_count);
        end
    end

    assign p_eff    = (i_cfg.pulses_per_step == '0) ? PPS_W'(1) : i_cfg.pulses_per_step;
    assign rd_addr  = (r_state == ST_CRUISE) ? r_cidx : r_idx;
    assign rd_steps = r_steps[rd_addr];
    assign rd_freq  = r_freq[rd_addr];
    assign seg      = SEG_W'(rd_steps) * SEG_W'(p_eff);
    assign acc_next = r_acc + ACC_W'({seg, 1'b0});
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_cidx    = r_cidx;
        n_rise    = r_rise;
        n_acc     = r_acc;
        n_cruise  = r_cruise;
        n_npulses = r_npulses;
        n_dir     = r_dir;
        o_pop     = 1'b0;
        tbl_we    = 1'b0;
        emit      = 1'b0;
        emit_data.seg_pulses    = PULSE_W'(seg);
        emit_data.seg_freq      = rd_freq;
        emit_data.seg_direction = r_dir;
        emit_data.seg_phase     = PH_ACCEL;
        emit_data.last          = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    if (!i_cmd.is_move) begin
                        tbl_we = 1'b1;
                    end else begin
                        n_npulses = i_cmd.pulse_total;
                        n_dir     = i_cmd.direction;
                        n_idx     = '0;
                        n_acc     = '0;
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (ACC_W'(r_npulses) <= acc_next) begin
                    // turn stair found: rise through the stairs below it
                    n_rise   = CNT_W'(r_idx);
                    n_cidx   = r_idx;
                    n_cruise = r_npulses - r_acc[PULSE_W-1:0];
                    n_idx    = '0;
                    n_state  = (r_idx == '0) ? ST_CRUISE : ST_RISE;
                end else if (CNT_W'(r_idx) == s_eff - CNT_W'(1)) begin
                    // move longer than the full ramp: full trapezoid
                    n_rise   = s_eff;
                    n_cidx   = r_idx;
                    n_cruise = r_npulses - acc_next[PULSE_W-1:0];
                    n_idx    = '0;
                    n_state  = ST_RISE;
                end else begin
                    n_idx = r_idx + TBL_AW'(1);
                    n_acc = acc_next;
                end
            end
            ST_RISE: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_data.seg_phase = PH_ACCEL;
                    if (CNT_W'(r_idx) == r_rise - CNT_W'(1)) begin
                        n_state = ST_CRUISE;
                    end else begin
                        n_idx = r_idx + TBL_AW'(1);
                    end
                end
            end
            ST_CRUISE: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_data.seg_pulses = r_cruise;
                    emit_data.seg_phase  = PH_CRUISE;
                    emit_data.last       = (r_rise == '0);
                    // r_idx already sits on the top rise stair
                    n_state = (r_rise == '0) ? ST_IDLE : ST_FALL;
                end
            end
            ST_FALL: begin
                if (out_free) begin
                    emit = 1'b1;
                    emit_data.seg_phase = PH_DECEL;
                    emit_data.last      = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - TBL_AW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cidx    <= n_cidx;
        r_rise    <= n_rise;
        r_acc     <= n_acc;
        r_cruise  <= n_cruise;
        r_npulses <= n_npulses;
        r_dir     <= n_dir;
        if (emit) begin
            r_out_data <= emit_data;
        end
        if (tbl_we) begin
            r_steps[TBL_AW'(i_cmd.stair_index)] <= i_cmd.stair_steps;
            r_freq[TBL_AW'(i_cmd.stair_index)]  <= i_cmd.stair_freq;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

// ===== rtl/stepper_stair_ramp_planner_top.sv =====
// Top level of the stepper stair ramp planner: config registers, front, queue, back.
// Depends on ssrp_pkg, ssrp_stream_if, ssrp_front, ssrp_queue, ssrp_back, assert_macros.svh.
//
// channel   dir  payload      per transaction
// i_in      in   t_in_item    one stair load or one move request
// o_out     out  t_out_item   one planned segment; last marks the end of a move
// i_cfg_*   in   7-bit data   one register write, index 0 stair_count, 1 pulses_per_step
//
// A load is written into the stair table as the back end dequeues it; a move with S
// stairs in use and turn stair k is dequeued, scans up to S stairs of the table (one
// stair per cycle through the 8x7 multiplier and 20-bit compare), then emits 2k+1
// segments (2S+1 for a full trapezoid).
// Reset clears the control state and config registers; the stair table is not cleared.
// A stalled output holds the back end in its emit state; the 2-entry queue lets
// the front keep taking items meanwhile.
`include "assert_macros.svh"

module stepper_stair_ramp_planner_top
    import ssrp_pkg::*;
#(
    parameter int MAX_STAIRS = MAX_STAIRS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssrp_stream_if.sink           i_in,
    ssrp_stream_if.source         o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [SC_W-1:0]  r_stair_count;
    logic [PPS_W-1:0] r_pulses_per_step;
    t_cfg             cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stair_count     <= SC_W'(1);
            r_pulses_per_step <= PPS_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STAIR_COUNT:     r_stair_count     <= i_cfg_data[SC_W-1:0];
                CFG_PULSES_PER_STEP: r_pulses_per_step <= i_cfg_data[PPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.stair_count     = r_stair_count;
    assign cfg.pulses_per_step = r_pulses_per_step;

    // front -> queue -> back
    logic    q_push;
    t_cmd    q_push_cmd;
    logic    q_pop;
    t_cmd    q_head;
    t_q_stat q_stat;

    ssrp_front #(
        .MAX_STAIRS (MAX_STAIRS)
    ) u_front (
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_cmd    (q_push_cmd)
    );

    ssrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_push_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    ssrp_back #(
        .MAX_STAIRS (MAX_STAIRS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (!q_stat.empty),
        .i_cmd       (q_head),
        .o_pop       (q_pop),
        .o_out       (o_out)
    );

    // queue bookkeeping between front and back
    `ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, q_push, !q_stat.full, "push into full queue")
    `ASSERT_IMPLY(a_pop_data, i_clk, i_rst_n, q_pop, !q_stat.empty, "pop from empty queue")
    `ASSERT_ALWAYS(a_ready_room, i_clk, i_rst_n, i_in.ready == !q_stat.full, "ready mismatch")

endmodule

// ===== tb/sv/stepper_stair_ramp_planner_top_tb.sv =====
// Testbench for stepper_stair_ramp_planner_top: stair loads, move requests and
// the segment stream. Depends on ssrp_pkg, ssrp_stream_if and the RTL top.
// Checks each segment against a local plan built from a copy of the stair table.
module stepper_stair_ramp_planner_top_tb;
    import ssrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Clock period is 10 ns; several times the slowest correct run fits well inside this.
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;
    // Quiet cycles before a register write and at the end (the back end works through each
    // move in turn, and two more commands may sit in the queue).
    localparam int unsigned SETTLE_CYCLES = 200;
    localparam int unsigned PHASES = 7;
    localparam int unsigned ITEMS_PER_PHASE = 13;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssrp_stream_if #(.T(t_in_item))  in_if ();
    ssrp_stream_if #(.T(t_out_item)) out_if ();

    stepper_stair_ramp_planner_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Local copy of the stair table as the block sees it (updated on accepted loads)
    logic [STEPS_W-1:0] tbl_steps [INDEX_SPAN];
    logic [FREQ_W-1:0]  tbl_freq  [INDEX_SPAN];
    // Step counts as queued by the stimulus, ahead of acceptance; used to aim moves
    logic [STEPS_W-1:0] queued_steps [INDEX_SPAN];
    // Register copies, reset values
    logic [SC_W-1:0]    cfg_stairs = SC_W'(1);
    logic [PPS_W-1:0]   cfg_pps    = PPS_W'(2);

    t_in_item    items_pending [$];
    t_out_item   segs_due [$];
    bit          idle_on;
    int unsigned src_gap;
    int unsigned sink_wait;
    int unsigned fail_count;
    t_out_item   seg_got;
    t_out_item   seg_want;

    // Stair count zero means one; anything above the table depth saturates.
    function automatic int unsigned eff_stairs();
        if (cfg_stairs == 0)
            return 1;
        if (cfg_stairs > MAX_STAIRS_DEF)
            return MAX_STAIRS_DEF;
        return cfg_stairs;
    endfunction

    function automatic int unsigned eff_pps();
        return (cfg_pps == 0) ? 1 : cfg_pps;
    endfunction

    function automatic string seg_str(t_out_item sg);
        return $sformatf("pulses=%0d freq=%0d dir=%0d phase=%0d last=%0d",
                         sg.seg_pulses, sg.seg_freq, sg.seg_direction,
                         sg.seg_phase, sg.last);
    endfunction

    function automatic void push_seg(int unsigned pulses, logic [FREQ_W-1:0] freq,
                                     logic dir, t_phase phase);
        t_out_item seg;
        seg.seg_pulses    = pulses[PULSE_W-1:0];
        seg.seg_freq      = freq;
        seg.seg_direction = dir;
        seg.seg_phase     = phase;
        seg.last          = 1'b0;
        segs_due.push_back(seg);
    endfunction

    // Applies one accepted transaction: a load updates the table copy, a move
    // appends its planned segments to segs_due.
    function automatic void plan_segments(t_in_item it);
        int unsigned s, p, n, span, acc, half, k;
        if (it.mode == MODE_LOAD) begin
            tbl_steps[it.stair_index] = it.stair_steps;
            tbl_freq[it.stair_index]  = it.stair_freq;
            return;
        end
        n = it.pulse_total;
        if (n == 0)
            return;
        s = eff_stairs();
        p = eff_pps();
        span = 0;
        for (int i = 0; i < s; i++)
            span += tbl_steps[i];
        span = 2 * p * span;
        if (n > span) begin
            // full trapezoid
            for (int i = 0; i < s; i++)
                push_seg(tbl_steps[i] * p, tbl_freq[i], it.direction, PH_ACCEL);
            push_seg(n - span, tbl_freq[s-1], it.direction, PH_CRUISE);
            for (int i = s; i > 0; i--)
                push_seg(tbl_steps[i-1] * p, tbl_freq[i-1], it.direction, PH_DECEL);
        end else if (n <= 2 * p * tbl_steps[0]) begin
            push_seg(n, tbl_freq[0], it.direction, PH_CRUISE);
        end else begin
            // partial trapezoid: turn at the first stair that covers half the move
            half = (n + 2 * p - 1) / (2 * p);
            acc = 0;
            k = 0;
            while (k < s && half > acc + tbl_steps[k]) begin
                acc += tbl_steps[k];
                k++;
            end
            if (k >= s)
                k = s - 1;
            for (int i = 0; i < k; i++)
                push_seg(tbl_steps[i] * p, tbl_freq[i], it.direction, PH_ACCEL);
            push_seg(n - 2 * p * acc, tbl_freq[k], it.direction, PH_CRUISE);
            for (int i = k; i > 0; i--)
                push_seg(tbl_steps[i-1] * p, tbl_freq[i-1], it.direction, PH_DECEL);
        end
        segs_due[segs_due.size()-1].last = 1'b1;
    endfunction

    // Load transaction; the move fields ride along with random values.
    function automatic void queue_load(int unsigned idx, int unsigned steps,
                                       int unsigned freq);
        t_in_item it;
        it.mode        = MODE_LOAD;
        it.stair_index = idx[IDX_W-1:0];
        it.stair_steps = steps[STEPS_W-1:0];
        it.stair_freq  = freq[FREQ_W-1:0];
        it.pulse_total = PULSE_W'($urandom);
        it.direction   = 1'($urandom);
        queued_steps[it.stair_index] = it.stair_steps;
        items_pending.push_back(it);
    endfunction

    // Move transaction; the load fields ride along with random values.
    function automatic void queue_move(int unsigned pulses);
        t_in_item it;
        it.mode        = MODE_MOVE;
        it.stair_index = IDX_W'($urandom);
        it.stair_steps = STEPS_W'($urandom);
        it.stair_freq  = FREQ_W'($urandom);
        it.pulse_total = pulses[PULSE_W-1:0];
        it.direction   = 1'($urandom);
        items_pending.push_back(it);
    endfunction

    // Block until all queued transactions are in and every segment is out,
    // then give the back end time to finish loads.
    task automatic wait_idle();
        while (items_pending.size() != 0 || in_if.valid || segs_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_STAIR_COUNT)
            cfg_stairs = val[SC_W-1:0];
        else
            cfg_pps = val[PPS_W-1:0];
    endtask

    // Driver: presents the next pending transaction once the previous one is
    // taken and its random gap has run out. Planning happens on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            src_gap <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid)
                plan_segments(in_if.data);
            if (src_gap != 0) begin
                src_gap <= src_gap - 1;
                in_if.valid <= 1'b0;
            end else if (items_pending.size() != 0) begin
                in_if.data  <= items_pending.pop_front();
                in_if.valid <= 1'b1;
                src_gap <= idle_on ? $urandom_range(0, 4) : 0;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted segment against the oldest planned one and
    // draws a random stall after every transaction while idle_on is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                seg_got = out_if.data;
                if (segs_due.size() == 0) begin
                    $display("%0t: unexpected segment %s", $time, seg_str(seg_got));
                    fail_count++;
                end else begin
                    seg_want = segs_due.pop_front();
                    if (seg_got.seg_pulses !== seg_want.seg_pulses
                        || seg_got.seg_freq !== seg_want.seg_freq
                        || seg_got.seg_direction !== seg_want.seg_direction
                        || seg_got.seg_phase !== seg_want.seg_phase
                        || seg_got.last !== seg_want.last) begin
                        $display("%0t: segment mismatch expected %s",
                                 $time, seg_str(seg_want));
                        $display("%0t:                  actual %s",
                                 $time, seg_str(seg_got));
                        fail_count++;
                    end
                end
                sink_wait = idle_on ? $urandom_range(0, 4) : 0;
            end else if (sink_wait != 0) begin
                sink_wait--;
            end
            out_if.ready <= (sink_wait == 0);
        end
    end

    initial begin : stimulus
        int unsigned s, p, span, first, n, stair_max;
        logic [CFG_DATA_W-1:0] sc_pick  [PHASES];
        logic [CFG_DATA_W-1:0] pps_pick [PHASES];

        // every block input known from time zero
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        idle_on      = 1'b1;
        fail_count   = 0;

        // register settings per random phase: extremes, out-of-range codes
        // (zero stairs, above table depth, bits beyond the field, zero pulses/step)
        sc_pick  = '{7'd16, 7'd0, 7'd31, 7'd17, 7'h65, 7'd1, 7'd0};
        pps_pick = '{7'd1, 7'd127, 7'd64, 7'd0, 7'd3, 7'd2, 7'd0};
        sc_pick[PHASES-1]  = CFG_DATA_W'($urandom);
        pps_pick[PHASES-1] = CFG_DATA_W'($urandom);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole table first so no move ever reads an entry never written.
        for (int i = 0; i < INDEX_SPAN; i++)
            queue_load(i, $urandom_range(0, 255), $urandom);
        queue_load(0, 3, 16'hFFFF);
        queue_load(15, 255, 0);

        // Reset settings, one stair of 3 steps at 2 pulses/step: 2*P*steps0 = 12.
        // Zero pulses, shortest single segment, single-segment boundary, full
        // trapezoid just past it, largest move.
        queue_move(0);
        queue_move(1);
        queue_move(12);
        queue_move(13);
        queue_move(65535);

        // Four stairs {2, 0, 5, 255} at 3 pulses/step: single boundary 12,
        // partial turn over a zero-step stair at 13, partial at the top stair at
        // T = 1572, full trapezoid from 1573.
        wait_idle();
        write_reg(CFG_STAIR_COUNT, 7'd4);
        write_reg(CFG_PULSES_PER_STEP, 7'd3);
        queue_load(0, 2, 16'h0000);
        queue_load(1, 0, 16'hFFFF);
        queue_load(2, 5, 16'h1234);
        queue_load(3, 255, 16'h8001);
        queue_move(12);
        queue_move(13);
        queue_move(1572);
        queue_move(1573);
        queue_move(65535);

        // Random phases: new settings each time, stairs mostly short in some phases
        // so that every plan shape is within reach of a 16-bit move.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            write_reg(CFG_STAIR_COUNT, sc_pick[ph]);
            write_reg(CFG_PULSES_PER_STEP, pps_pick[ph]);
            idle_on = ($urandom_range(0, 3) != 0);
            stair_max = ($urandom_range(0, 1) != 0) ? 6 : 255;
            for (int it = 0; it < ITEMS_PER_PHASE; it++) begin
                if ($urandom_range(0, 9) < 3) begin
                    queue_load($urandom_range(0, INDEX_SPAN - 1),
                               $urandom_range(0, stair_max), $urandom);
                end else begin
                    s = eff_stairs();
                    p = eff_pps();
                    span = 0;
                    for (int i = 0; i < s; i++)
                        span += queued_steps[i];
                    span = 2 * p * span;
                    first = 2 * p * queued_steps[0];
                    n = $urandom_range(0, 65535);
                    case ($urandom_range(0, 9))
                        0: n = 0;
                        1, 2: if (first != 0)
                            n = $urandom_range(1, (first < 65535) ? first : 65535);
                        3, 4, 5: if (span > first && first < 65535)
                            n = $urandom_range(first + 1, (span < 65535) ? span : 65535);
                        6, 7: if (span < 65535)
                            n = $urandom_range(span + 1, 65535);
                        default: ;
                    endcase
                    queue_move(n);
                end
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("stepper_stair_ramp_planner_top_tb OK");
        else
            $display("stepper_stair_ramp_planner_top_tb NOT OK");
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("stepper_stair_ramp_planner_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== stepper_stair_ramp_planner_top.f =====
+incdir+rtl
rtl/ssrp_pkg.sv
rtl/ssrp_stream_if.sv
rtl/ssrp_front.sv
rtl/ssrp_queue.sv
rtl/ssrp_back.sv
rtl/stepper_stair_ramp_planner_top.sv
tb/sv/stepper_stair_ramp_planner_top_tb.sv
